// ===== hdl/ohsa_pkg.sv =====
// Package for the orbit heat-map splat accumulator: shared types and constants.
// Depends on nothing; every other file but the checker refers to it by scoped names.
`timescale 1ns / 1ps
package ohsa_pkg;
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_SCALE_X  = 3'd2;
    localparam logic [2:0] REG_SCALE_Y  = 3'd3;
    localparam logic [2:0] REG_WIDTH    = 3'd4;
    localparam logic [2:0] REG_HEIGHT   = 3'd5;
    localparam logic [2:0] REG_MODE     = 3'd6;

    localparam logic [2:0] MODE_MIRROR_Y = 3'd0;
    localparam logic [2:0] MODE_OFFSET_X = 3'd1;
    localparam logic [2:0] MODE_OFFSET_Y = 3'd3;
    localparam logic [2:0] MODE_FOLD     = 3'd6;

    localparam logic signed [35:0] FOLD_SHIFT_X = 36'sd33554432;
    localparam logic signed [35:0] FOLD_ADD_Y   = 36'sd41607496;
    localparam logic signed [47:0] QUARTER_PX   = 48'sd16384;
    localparam logic signed [47:0] TENTH_PX     = -48'sd6554;

    // Reciprocal of three: floor(u / 3) = (u * THIRD_RECIP) >> 33 for any 32-bit u.
    localparam logic [31:0] THIRD_RECIP = 32'hAAAA_AAAB;

    // One splat job handed from the front end to the back end.
    typedef struct packed {
        logic               drop;      // point fell outside the view
        logic signed [47:0] px;        // primary splat, Q16.16
        logic signed [47:0] py;
        logic               mirror;    // second splat present
        logic signed [47:0] mx;        // mirrored splat, Q16.16
        logic signed [47:0] my;
    } splat_job_t;
endpackage

// ===== hdl/ohsa_front.sv =====
// Front end: maps one orbit point to pixel space, folds and mirrors per mode.
// Depends on ohsa_pkg. One shared 37x32 multiplier is sequenced over the axes.
`timescale 1ns / 1ps
module ohsa_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [31:0]       point_x,
    input  logic signed [31:0]       point_y,
    input  logic signed [31:0]       origin_x,
    input  logic signed [31:0]       origin_y,
    input  logic [31:0]              scale_x,
    input  logic [31:0]              scale_y,
    input  logic [16:0]              lim_w,     // width limit in pixels, scaled by 65536 for the compare
    input  logic [16:0]              lim_h,
    input  logic [2:0]               mode,
    output logic                     job_valid,
    input  logic                     job_ready,
    output ohsa_pkg::splat_job_t     job
);
    // Sequencer steps.
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MX   = 8'b0000_0010,
        S_MY   = 8'b0000_0100,
        S_FOLD = 8'b0000_1000,
        S_M2X  = 8'b0001_0000,
        S_M2Y  = 8'b0010_0000,
        S_M3   = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } fstate_t;

    fstate_t state_reg, state_next;
    logic signed [35:0] zx_reg, zy_reg;
    logic signed [47:0] px_reg, py_reg, mx_reg, my_reg;
    logic [2:0]  mode_reg;
    logic        drop_reg;

    // Shared axis mapper: floor((z - org) * scale / 2^28).
    logic signed [35:0] mz;
    logic signed [31:0] morg;
    logic [31:0]        mscl;
    logic signed [36:0] md;
    logic [36:0]        mabs;
    logic [68:0]        mprod;
    logic [40:0]        mq;
    logic               mround;
    logic signed [47:0] mres;

    always_comb
    begin
        mz   = zx_reg;
        morg = origin_x;
        mscl = scale_x;
        case (state_reg)
            S_MY, S_M2Y:
            begin
                mz = zy_reg; morg = origin_y; mscl = scale_y;
            end
            S_M3:
            begin
                if (mode_reg == ohsa_pkg::MODE_FOLD)
                begin
                    mz = -zx_reg;
                end
                else
                begin
                    mz = -zy_reg; morg = origin_y; mscl = scale_y;
                end
            end
            default:
            begin
                mz = zx_reg;
            end
        endcase
        md     = 37'(mz) - 37'(morg);
        mabs   = md[36] ? 37'(-md) : md;
        mprod  = 69'(mabs) * 69'(mscl);
        mq     = mprod[68:28];
        mround = md[36] && (mprod[27:0] != 28'd0);
        mres   = md[36] ? -(48'(mq) + 48'(mround)) : 48'(mq);
    end

    // Fold arithmetic in Q4.28 with extra headroom. For a magnitude u below 2^32,
    // floor(4u / 3) is u + floor(u / 3), and the third comes from a reciprocal product.
    logic signed [35:0] ft;
    logic [31:0]        fux, fuy;
    logic [63:0]        fpx, fpy;
    logic [35:0]        fqx, fqy;
    always_comb
    begin
        ft  = zx_reg - ohsa_pkg::FOLD_SHIFT_X;
        fux = ft[35] ? 32'(-ft) : 32'(ft);
        fuy = zy_reg[35] ? 32'(-zy_reg) : 32'(zy_reg);
        fpx = 64'(fux) * 64'(ohsa_pkg::THIRD_RECIP);
        fpy = 64'(fuy) * 64'(ohsa_pkg::THIRD_RECIP);
        fqx = 36'(fux) + 36'(fpx[63:33]);
        fqy = 36'(fuy) + 36'(fpy[63:33]);
    end

    function automatic logic in_range(input logic signed [47:0] v, input logic [16:0] lim);
        in_range = !v[47] && (v < $signed({7'd0, lim, 24'd0} >>> 8));
    endfunction

    logic signed [47:0] offx, offy;
    always_comb
    begin
        offx = '0;
        offy = '0;
        if (mode_reg == ohsa_pkg::MODE_MIRROR_Y || mode_reg == ohsa_pkg::MODE_OFFSET_X)
            offx = ohsa_pkg::QUARTER_PX;
        if (mode_reg == ohsa_pkg::MODE_OFFSET_Y)
            offy = ohsa_pkg::TENTH_PX;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign job_valid = (state_reg == S_OUT);
    assign job.drop   = drop_reg;
    assign job.px     = px_reg;
    assign job.py     = py_reg;
    assign job.mirror = (mode_reg == ohsa_pkg::MODE_MIRROR_Y) ||
                        (mode_reg == ohsa_pkg::MODE_FOLD);
    assign job.mx     = mx_reg;
    assign job.my     = my_reg;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_MX;
            S_MX:   state_next = S_MY;
            S_MY:
            begin
                if (!in_range(px_reg, lim_w) || !in_range(mres, lim_h))
                    state_next = S_OUT;
                else if (mode_reg == ohsa_pkg::MODE_FOLD)
                    state_next = S_FOLD;
                else
                    state_next = S_M2X;
            end
            S_FOLD: state_next = S_M2X;
            S_M2X:  state_next = S_M2Y;
            S_M2Y:  state_next = S_M3;
            S_M3:   state_next = S_OUT;
            S_OUT:  if (job_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                zx_reg   <= 36'(point_x);
                zy_reg   <= 36'(point_y);
                mode_reg <= mode;
                drop_reg <= 1'b0;
            end
            S_MX: px_reg <= mres;
            S_MY:
            begin
                if (!in_range(px_reg, lim_w) || !in_range(mres, lim_h))
                    drop_reg <= 1'b1;
            end
            S_FOLD:
            begin
                zx_reg <= 36'(fqx);
                zy_reg <= (zy_reg[35] ? fqy : -fqy) + ohsa_pkg::FOLD_ADD_Y;
            end
            S_M2X: px_reg <= mres + offx;
            S_M2Y:
            begin
                py_reg <= mres + offy;
                if (!in_range(px_reg, lim_w) || !in_range(mres + offy, lim_h))
                    drop_reg <= 1'b1;
            end
            S_M3:
            begin
                if (mode_reg == ohsa_pkg::MODE_FOLD)
                begin
                    mx_reg <= mres + offx;
                    my_reg <= py_reg;
                end
                else
                begin
                    mx_reg <= px_reg;
                    my_reg <= mres + offy;
                end
            end
            default:
            begin
                drop_reg <= drop_reg;
            end
        endcase
    end
endmodule

// ===== hdl/ohsa_queue.sv =====
// Two-entry job queue between front end and back end.
// Depends on ohsa_pkg for the job type.
`timescale 1ns / 1ps
module ohsa_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  ohsa_pkg::splat_job_t wr_data,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output ohsa_pkg::splat_job_t rd_data
);
    ohsa_pkg::splat_job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule

// ===== hdl/ohsa_back.sv =====
// Back end: read-modify-write of heat cells through one memory port, with peak.
// Depends on ohsa_pkg. Holds the count store and its clearing pass.
`timescale 1ns / 1ps
module ohsa_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int COUNT_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  ohsa_pkg::splat_job_t job,
    input  logic [12:0]          w,          // clamped width
    input  logic [12:0]          h,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          peak_count,
    output logic [3:0]           cells_bumped
);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    typedef enum logic [5:0] {
        B_CLEAR = 6'b000001,
        B_IDLE  = 6'b000010,
        B_ADDR  = 6'b000100,
        B_READ  = 6'b001000,
        B_WRITE = 6'b010000,
        B_OUT   = 6'b100000
    } bstate_t;

    bstate_t state_reg, state_next;
    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] rd_reg;
    logic [AW-1:0]   clr_reg;
    logic [AW-1:0]   addr_reg;
    logic [3:0]      k_reg;       // 0..9 neighbour step over both splats
    logic [3:0]      n_reg;
    logic [31:0]     peak_reg;
    ohsa_pkg::splat_job_t job_reg;

    // Current splat cell.
    logic signed [47:0] sx, sy;
    logic signed [32:0] cx, cy, col, row;
    logic signed [47:0] idx;
    logic signed [47:0] area;
    logic               ok;
    logic [2:0]         nb;
    always_comb
    begin
        sx = (k_reg < 4'd5) ? job_reg.px : job_reg.mx;
        sy = (k_reg < 4'd5) ? job_reg.py : job_reg.my;
        nb = (k_reg < 4'd5) ? 3'(k_reg) : 3'(k_reg - 4'd5);
        cx = 33'(sx >>> 16);
        cy = 33'(sy >>> 16);
        col = cx;
        row = cy;
        case (nb)
            3'd1: col = cx - 33'sd1;
            3'd2: col = cx + 33'sd1;
            3'd3: row = cy - 33'sd1;
            3'd4: row = cy + 33'sd1;
            default: col = cx;
        endcase
        idx  = 48'(row) * $signed({35'd0, w}) + 48'(col);
        area = $signed({35'd0, w}) * $signed({35'd0, h});
        ok   = !idx[47] && (idx < area);
    end

    logic [COUNT_BITS:0] sum;
    logic [COUNT_BITS-1:0] newv;
    always_comb
    begin
        sum  = {1'b0, rd_reg} + ((k_reg < 4'd5 && n_reg == 4'd0) ? (COUNT_BITS+1)'(2)
                                                                 : (COUNT_BITS+1)'(1));
        newv = sum[COUNT_BITS] ? CMAX : sum[COUNT_BITS-1:0];
    end

    logic last_k;
    assign last_k = (k_reg == 4'd9) || (k_reg == 4'd4 && !job_reg.mirror);

    assign job_ready    = (state_reg == B_IDLE);
    assign out_valid    = (state_reg == B_OUT);
    assign peak_count   = peak_reg;
    assign cells_bumped = n_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR: if (clr_reg == AW'(DEPTH - 1)) state_next = B_IDLE;
            B_IDLE:  if (job_valid) state_next = B_ADDR;
            B_ADDR:
            begin
                if (job_reg.drop) state_next = B_OUT;
                else if (ok) state_next = B_READ;
                else if (last_k) state_next = B_OUT;
            end
            B_READ:  state_next = B_WRITE;
            B_WRITE: state_next = last_k ? B_OUT : B_ADDR;
            B_OUT:   if (out_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            clr_reg   <= '0;
            peak_reg  <= '0;
            k_reg     <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                B_CLEAR: clr_reg <= clr_reg + AW'(1);
                B_IDLE:
                begin
                    k_reg <= '0;
                    n_reg <= '0;
                end
                B_ADDR:
                begin
                    if (!job_reg.drop && !ok && !last_k)
                        k_reg <= k_reg + 4'd1;
                end
                B_WRITE:
                begin
                    n_reg <= n_reg + 4'd1;
                    if (32'(newv) > peak_reg)
                        peak_reg <= 32'(newv);
                    if (!last_k)
                        k_reg <= k_reg + 4'd1;
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    // Job capture, address register and the single-port count store.
    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && job_valid)
            job_reg <= job;
        if (state_reg == B_ADDR)
            addr_reg <= idx[AW-1:0];
        if (state_reg == B_CLEAR)
            mem[clr_reg] <= '0;
        else if (state_reg == B_WRITE)
            mem[addr_reg] <= newv;
        if (state_reg == B_READ)
            rd_reg <= mem[addr_reg];
    end
endmodule

// ===== hdl/orbit_heatmap_splat_accumulator.sv =====
// Top level of the orbit heat-map splat accumulator: registers, front, queue, back.
// Depends on ohsa_pkg, ohsa_front, ohsa_queue and ohsa_back.
`timescale 1ns / 1ps
// One result transaction follows every accepted point. The front end maps a point
// on one shared multiplier and takes the next point in the cycle after handing its
// job on; the back end updates each in-view cell, at most ten per point, by
// read-modify-write through a single memory port (address, read and write steps)
// and skips an off-image neighbour in its address step alone, and the back end
// usually sets the rate. A two-entry queue lets the front map the next point
// meanwhile. After reset the count store is cleared one entry per cycle before
// points are processed; configuration registers should be written only while no
// point is in flight.
module orbit_heatmap_splat_accumulator #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int COUNT_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        peak_count,
    output logic [3:0]         cells_bumped,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    logic signed [31:0] origin_x_reg, origin_y_reg;
    logic [31:0] scale_x_reg, scale_y_reg;
    logic [8:0]  width_reg, height_reg;
    logic [2:0]  mode_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= -32'sd536870912;
            origin_y_reg <= -32'sd536870912;
            scale_x_reg  <= 32'd4194304;
            scale_y_reg  <= 32'd4194304;
            width_reg    <= 9'd256;
            height_reg   <= 9'd256;
            mode_reg     <= 3'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ohsa_pkg::REG_ORIGIN_X: origin_x_reg <= cfg_data;
                ohsa_pkg::REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                ohsa_pkg::REG_SCALE_X:  scale_x_reg  <= cfg_data;
                ohsa_pkg::REG_SCALE_Y:  scale_y_reg  <= cfg_data;
                ohsa_pkg::REG_WIDTH:    width_reg    <= cfg_data[8:0];
                ohsa_pkg::REG_HEIGHT:   height_reg   <= cfg_data[8:0];
                ohsa_pkg::REG_MODE:     mode_reg     <= cfg_data[2:0];
                default:                mode_reg     <= mode_reg;
            endcase
        end
    end

    // Clamp sizes to the store's dimensions.
    logic [12:0] w_c, h_c;
    assign w_c = (13'(width_reg) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(width_reg);
    assign h_c = (13'(height_reg) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(height_reg);

    logic fj_valid, fj_ready, bj_valid, bj_ready;
    ohsa_pkg::splat_job_t fjob, bjob;

    ohsa_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .point_x(point_x), .point_y(point_y),
        .origin_x(origin_x_reg), .origin_y(origin_y_reg),
        .scale_x(scale_x_reg), .scale_y(scale_y_reg),
        .lim_w(17'(w_c)), .lim_h(17'(h_c)), .mode(mode_reg),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fjob)
    );

    ohsa_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fjob),
        .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bjob)
    );

    ohsa_back #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .COUNT_BITS(COUNT_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bjob),
        .w(w_c), .h(h_c),
        .out_valid(out_valid), .out_ready(out_ready),
        .peak_count(peak_count), .cells_bumped(cells_bumped)
    );
endmodule

// ===== hdl/ohsa_checker.sv =====
// Port-level checker for the splat accumulator, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module ohsa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] peak_count,
    input logic [3:0]  cells_bumped
);
    // A stalled result transaction stays valid and holds its peak count.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(peak_count))
        else $error("result changed while stalled");

    // The peak never falls between successive results.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> peak_count >= $past(peak_count))
        else $error("peak decreased");

    // At most ten cells per point: five for each of the two splats.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cells_bumped <= 4'd10)
        else $error("bad cell count");

    // A point that bumped cells leaves a nonzero peak.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cells_bumped != 4'd0 |-> peak_count != 32'd0)
        else $error("peak zero after bump");
endmodule

bind orbit_heatmap_splat_accumulator ohsa_checker u_ohsa_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .peak_count(peak_count), .cells_bumped(cells_bumped)
);
